// File: src/psu_pkg.sv
// shared types and constants for the png scanline unfilter
package psu_pkg;

	// line store and history sizing
	localparam int MAX_ROW_BYTES   = 8192;
	localparam int MAX_PIXEL_BYTES = 8;
	localparam int COL_W           = $clog2(MAX_ROW_BYTES);
	localparam int POS_W           = $clog2(MAX_ROW_BYTES + 1);
	localparam int HIST_W          = 8 * MAX_PIXEL_BYTES;
	localparam int PIX_IDX_W       = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	// configuration register widths
	localparam int ROW_BYTES_W = 14;
	localparam int BPP_W       = 4;
	localparam int CFG_DATA_W  = 14;
	localparam int CFG_IDX_W   = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 1'd1;

	// filter type codes
	typedef enum logic [2:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4
	} filter_t;

	// input transfer payload
	typedef struct packed {
		logic [7:0] byte_value;
		logic       frame_start;
	} in_item_t;

	// output transfer payload
	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       row_end;
		logic       bad_filter;
	} out_item_t;

endpackage

// File: src/png_scanline_unfilter.sv
// png scanline filter reconstruction (none, sub, up, average, paeth)
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall    in_item_t  (byte_value, frame_start)
//  out      output     out_valid / out_stall  out_item_t (pixel_byte, row_end, bad_filter)
//  cfg      input      cfg_write              cfg_index, cfg_data
//
// one byte per cycle while in_stall is low; a data byte shows its result in the cycle after its transfer
// the line store is read ahead at the next column, so its data is ready
// when the byte arrives; a type byte gives no result
// reset needs no clearing pass: a first row reads no line store data
// in_stall is high only while a result waits in the output register and is stalled
module png_scanline_unfilter import psu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [ROW_BYTES_W-1:0] row_bytes_q;
	logic [BPP_W-1:0]       bpp_q;
	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       pos_next;
	filter_t                filter_q;
	logic                   first_q;
	logic                   err_q;
	logic [HIST_W-1:0]      cur_hist_q;
	logic [HIST_W-1:0]      pri_hist_q;
	logic                   out_valid_q;
	out_item_t              out_data_q;

	logic [POS_W-1:0]     eff_rb;
	logic [BPP_W-1:0]     eff_bpp;
	logic [PIX_IDX_W-1:0] bidx;
	logic [COL_W-1:0]     col;
	logic [COL_W-1:0]     rd_col;
	logic                 accept;
	logic                 is_type;
	logic                 last;
	logic [7:0]           ram_rdata;
	logic [7:0]           a;
	logic [7:0]           b;
	logic [7:0]           c;
	logic [7:0]           pred;
	logic [7:0]           res;
	logic [8:0]           avg_sum;
	logic signed [9:0]    d_pa;
	logic signed [9:0]    d_pb;
	logic signed [9:0]    d_pc;
	logic [9:0]           pa;
	logic [9:0]           pb;
	logic [9:0]           pc;
	logic [7:0]           paeth;

	// handshake
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// clamped register values
	always_comb begin
		if (row_bytes_q == '0) begin
			eff_rb = POS_W'(1);
		end else if (int'(row_bytes_q) > MAX_ROW_BYTES) begin
			eff_rb = POS_W'(MAX_ROW_BYTES);
		end else begin
			eff_rb = POS_W'(row_bytes_q);
		end
		if (bpp_q == '0) begin
			eff_bpp = BPP_W'(1);
		end else if (int'(bpp_q) > MAX_PIXEL_BYTES) begin
			eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
		end else begin
			eff_bpp = bpp_q;
		end
		bidx = PIX_IDX_W'(eff_bpp - BPP_W'(1));
	end

	// column tracking and line store read address
	always_comb begin
		is_type = (pos_q == '0);
		col     = COL_W'(pos_q - POS_W'(1));
		last    = (pos_q >= eff_rb);
		if (!accept) begin
			pos_next = pos_q;
		end else if (is_type) begin
			pos_next = POS_W'(1);
		end else if (last) begin
			pos_next = '0;
		end else begin
			pos_next = pos_q + POS_W'(1);
		end
		rd_col = (pos_next == '0) ? '0 : COL_W'(pos_next - POS_W'(1));
	end

	// neighbors
	always_comb begin
		b = first_q ? 8'd0 : ram_rdata;
		if (int'(col) >= int'(eff_bpp)) begin
			a = cur_hist_q[{bidx, 3'b000} +: 8];
			c = pri_hist_q[{bidx, 3'b000} +: 8];
		end else begin
			a = 8'd0;
			c = 8'd0;
		end
	end

	// paeth predictor, ties go left, then up, then upper-left
	always_comb begin
		d_pa = $signed({2'b00, b}) - $signed({2'b00, c});
		d_pb = $signed({2'b00, a}) - $signed({2'b00, c});
		d_pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
		pa   = d_pa[9] ? 10'(-d_pa) : 10'(d_pa);
		pb   = d_pb[9] ? 10'(-d_pb) : 10'(d_pb);
		pc   = d_pc[9] ? 10'(-d_pc) : 10'(d_pc);
		if (pa <= pb && pa <= pc) begin
			paeth = a;
		end else if (pb <= pc) begin
			paeth = b;
		end else begin
			paeth = c;
		end
	end

	// prediction and reconstruction
	always_comb begin
		avg_sum = {1'b0, a} + {1'b0, b};
		case (filter_q)
			FLT_SUB:   pred = a;
			FLT_UP:    pred = b;
			FLT_AVG:   pred = avg_sum[8:1];
			FLT_PAETH: pred = paeth;
			default:   pred = 8'd0;
		endcase
		res = in_data.byte_value + pred;
	end

	// prior row line store
	psu_ram #(
		.WIDTH (8),
		.DEPTH (MAX_ROW_BYTES)
	) u_line_store (
		.clk   (clk),
		.we    (accept & ~is_type),
		.waddr (col),
		.wdata (res),
		.raddr (rd_col),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= ROW_BYTES_W'(1);
			bpp_q       <= BPP_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ROW_BYTES: row_bytes_q <= ROW_BYTES_W'(cfg_data);
				CFG_BPP:       bpp_q       <= cfg_data[BPP_W-1:0];
				default:       ;
			endcase
		end
	end

	// row state and histories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			filter_q   <= FLT_NONE;
			first_q    <= 1'b1;
			err_q      <= 1'b0;
			cur_hist_q <= '0;
			pri_hist_q <= '0;
		end else begin
			pos_q <= pos_next;
			if (accept && is_type) begin
				if (in_data.frame_start) begin
					first_q <= 1'b1;
				end
				if (in_data.byte_value > 8'd4) begin
					err_q    <= 1'b1;
					filter_q <= FLT_NONE;
				end else begin
					err_q    <= 1'b0;
					filter_q <= filter_t'(in_data.byte_value[2:0]);
				end
				cur_hist_q <= '0;
				pri_hist_q <= '0;
			end else if (accept) begin
				cur_hist_q <= HIST_W'({cur_hist_q, res});
				pri_hist_q <= HIST_W'({pri_hist_q, b});
				if (last) begin
					first_q <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && !is_type) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_type) begin
			out_data_q.pixel_byte <= res;
			out_data_q.row_end    <= last;
			out_data_q.bad_filter <= err_q;
		end
	end

	// a type byte transfer leaves no result behind
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_type) |=> !out_valid_q)
		else $error("type byte produced a result");

	// a data byte transfer always yields a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_type) |=> out_valid_q)
		else $error("data byte lost its result");

	// the filter error flag holds across the data bytes of a row
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_type) |=> $stable(err_q))
		else $error("filter error changed inside a row");

	// the column never passes the line store size
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) <= MAX_ROW_BYTES)
		else $error("column position out of range");

endmodule

// File: src/psu_ram.sv
// generic single-write, single-read ram with registered read data
module psu_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
